// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the peak finder RTL.
// Each macro expects clk and rst_n in the scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/wlpf_pkg.sv =====
// Shared types and constants of the windowed local peak finder.
// No dependencies; every module of the block imports this package.
package wlpf_pkg;

  // field widths
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned IDX_W       = 12;
  localparam int unsigned LEN_W       = 13;
  localparam int unsigned MAX_SAMPLES = 4096;

  // register port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_RECORD_LENGTH = 1'b0;
  localparam logic [LEN_W-1:0] RECORD_LENGTH_RST = 13'd4096;

  // result queue
  localparam int unsigned OUTQ_DEPTH = 3;
  localparam int unsigned OUTQ_PTR_W = 2;
  localparam int unsigned OUTQ_CNT_W = 2;

  // result kinds
  localparam logic KIND_DECISION = 1'b0;
  localparam logic KIND_SUMMARY  = 1'b1;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [LEN_W-1:0]    len_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_SUM
  } state_t;

  // one result word
  typedef struct packed {
    logic    result_kind;
    idx_t    sample_index;
    logic    is_candidate;
    sample_t decided_value;
    idx_t    first_index;
    sample_t first_value;
    logic    first_valid;
    idx_t    second_index;
    sample_t second_value;
    logic    second_valid;
    logic    last_of_run;
  } result_t;

  // two largest candidates of the current record
  typedef struct packed {
    sample_t best_value;
    idx_t    best_index;
    logic    best_valid;
    sample_t runner_value;
    idx_t    runner_index;
    logic    runner_valid;
  } top2_t;

endpackage

// ===== rtl/core/windowed_local_peak_finder.sv =====
// Top level of the windowed local peak finder: window row, rule, tracker, queue.
// Depends on wlpf_pkg, wlpf_cell, wlpf_judge, wlpf_top2, wlpf_outq, assert_macros.svh.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_stall     in_sample_value
//   out_     output     out_valid / out_stall   result_kind .. last_of_run
//   cfg_     input      psel/penable/pwrite     record_length at byte address 0
//
// One sample per cycle while a record runs and the queue has room; the decision it
// completes (HALF_WINDOW samples back) enters a three-word queue at the next edge and
// is offered on out_ after it. After the last sample of a record, in_stall stays high while
// HALF_WINDOW empty shifts flush the row, then the last decision and summary are queued.
// Reset is synchronous and active low; record_length resets to 4096.
// A stalled output holds the queue head; the row stops shifting before the queue is full.
`include "assert_macros.svh"

module windowed_local_peak_finder #(
  parameter int unsigned HALF_WINDOW = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  wlpf_pkg::sample_t                    in_sample_value,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_result_kind,
  output wlpf_pkg::idx_t                       out_sample_index,
  output logic                                 out_is_candidate,
  output wlpf_pkg::sample_t                    out_decided_value,
  output wlpf_pkg::idx_t                       out_first_index,
  output wlpf_pkg::sample_t                    out_first_value,
  output logic                                 out_first_valid,
  output wlpf_pkg::idx_t                       out_second_index,
  output wlpf_pkg::sample_t                    out_second_value,
  output logic                                 out_second_valid,
  output logic                                 out_last_of_run,
  // register port
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [wlpf_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [wlpf_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [wlpf_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);
  import wlpf_pkg::*;

  localparam int unsigned CHAIN_LEN = 2 * HALF_WINDOW + 1;
  localparam int unsigned BUB_W     = (HALF_WINDOW > 1) ? $clog2(HALF_WINDOW) : 1;
  localparam int unsigned ROOM_W    = OUTQ_CNT_W + 1;

  // register port
  len_t len_r;
  len_t len_eff;
  logic cfg_wr;

  // control
  state_t            state_r, state_nxt;
  len_t              sh_cnt_r;
  len_t              total_r;
  logic [BUB_W-1:0]  bub_cnt_r;
  logic              due_r;
  logic              room;
  logic              shift;
  logic              chain_in_valid;
  logic              sum_push;
  logic              clear;
  logic              accept;
  len_t              n_plus1;
  logic              at_end;
  logic              bub_last;

  // window row
  sample_t                 cell_value [CHAIN_LEN];
  sample_t                 cell_d_value [CHAIN_LEN];
  logic [CHAIN_LEN-1:0]    cell_valid;
  logic [CHAIN_LEN-1:0]    cell_d_valid;
  logic [CHAIN_LEN-1:0]    cell_lower;

  // results
  idx_t                    centre_index;
  result_t                 decision;
  result_t                 summary;
  result_t                 push_data;
  result_t                 head;
  top2_t                   top;
  logic [OUTQ_CNT_W-1:0]   q_count;

  // register write and read
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                   && (cfg_paddr[CFG_ADDR_W-1:2] == REG_RECORD_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= RECORD_LENGTH_RST;
    end else if (cfg_wr) begin
      len_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_RECORD_LENGTH)
                    ? CFG_DATA_W'(len_r) : '0;

  // clamp the record length
  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_SAMPLES)) begin
      len_eff = LEN_W'(MAX_SAMPLES);
    end else begin
      len_eff = len_r;
    end
  end

  // queue room for the word now pending and the one the next shift makes
  assign room     = (ROOM_W'(q_count) + ROOM_W'(due_r)) <= ROOM_W'(OUTQ_DEPTH - 1);
  assign n_plus1  = sh_cnt_r + 1'b1;
  assign at_end   = n_plus1 >= len_eff;
  assign bub_last = (bub_cnt_r == BUB_W'(HALF_WINDOW - 1));
  assign accept   = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (accept && at_end) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (shift && bub_last) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (sum_push) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall       = 1'b1;
    shift          = 1'b0;
    chain_in_valid = 1'b0;
    sum_push       = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        in_stall       = !room;
        shift          = in_valid && room;
        chain_in_valid = 1'b1;
      end
      ST_FLUSH: begin
        shift = room;
      end
      ST_SUM: begin
        sum_push = !due_r && (q_count < OUTQ_CNT_W'(OUTQ_DEPTH));
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign clear = sum_push;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RUN;
      sh_cnt_r  <= '0;
      bub_cnt_r <= '0;
      due_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      due_r   <= shift && cell_valid[HALF_WINDOW-1];
      if (clear) begin
        sh_cnt_r  <= '0;
        bub_cnt_r <= '0;
      end else begin
        if (shift) begin
          sh_cnt_r <= n_plus1;
        end
        if ((state_r == ST_FLUSH) && shift) begin
          bub_cnt_r <= bub_cnt_r + 1'b1;
        end
      end
    end
  end

  // hold the record length that applies to the pending decision
  always_ff @(posedge clk) begin
    if (accept) begin
      total_r <= at_end ? n_plus1 : len_eff;
    end
  end

  // window row: cell 0 takes the newest sample
  for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_d_value[k] = in_sample_value;
      assign cell_d_valid[k] = chain_in_valid;
    end else begin : g_link
      assign cell_d_value[k] = cell_value[k-1];
      assign cell_d_valid[k] = cell_valid[k-1];
    end

    wlpf_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .shift_en     (shift),
      .clear        (clear),
      .d_value      (cell_d_value[k]),
      .d_valid      (cell_d_valid[k]),
      .centre_value (cell_value[HALF_WINDOW]),
      .q_value      (cell_value[k]),
      .q_valid      (cell_valid[k]),
      .lower        (cell_lower[k])
    );
  end

  assign centre_index = IDX_W'(sh_cnt_r - LEN_W'(HALF_WINDOW + 1));

  // decide the centre sample
  wlpf_judge #(
    .HALF_WINDOW (HALF_WINDOW)
  ) u_judge (
    .centre_index (centre_index),
    .centre_value (cell_value[HALF_WINDOW]),
    .total        (total_r),
    .lower_left   (cell_lower[CHAIN_LEN-1:HALF_WINDOW+1]),
    .lower_right  (cell_lower[HALF_WINDOW-1:0]),
    .decision     (decision)
  );

  // track the two largest candidates
  wlpf_top2 u_top2 (
    .clk        (clk),
    .rst_n      (rst_n),
    .note       (due_r && decision.is_candidate),
    .clear      (clear),
    .cand_value (decision.decided_value),
    .cand_index (decision.sample_index),
    .top        (top)
  );

  // end-of-record summary word
  always_comb begin
    summary             = '0;
    summary.result_kind = KIND_SUMMARY;
    summary.last_of_run = 1'b1;
    if (top.best_valid) begin
      summary.first_index = top.best_index;
      summary.first_value = top.best_value;
      summary.first_valid = 1'b1;
    end
    if (top.runner_valid) begin
      summary.second_index = top.runner_index;
      summary.second_value = top.runner_value;
      summary.second_valid = 1'b1;
    end
  end

  assign push_data = due_r ? decision : summary;

  wlpf_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (due_r || sum_push),
    .push_data (push_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .count     (q_count)
  );

  assign out_result_kind   = head.result_kind;
  assign out_sample_index  = head.sample_index;
  assign out_is_candidate  = head.is_candidate;
  assign out_decided_value = head.decided_value;
  assign out_first_index   = head.first_index;
  assign out_first_value   = head.first_value;
  assign out_first_valid   = head.first_valid;
  assign out_second_index  = head.second_index;
  assign out_second_value  = head.second_value;
  assign out_second_valid  = head.second_valid;
  assign out_last_of_run   = head.last_of_run;

  `ASSERT_NEXT(a_row_cleared, sum_push, (cell_valid == '0) && (sh_cnt_r == '0) && (state_r == ST_RUN), "window row not cleared after summary")

endmodule

// ===== rtl/core/wlpf_cell.sv =====
// One window cell: holds a sample and its in-record flag, hands both on.
// Depends on wlpf_pkg.
module wlpf_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_en,
  input  logic             clear,
  input  wlpf_pkg::sample_t d_value,
  input  logic             d_valid,
  input  wlpf_pkg::sample_t centre_value,
  output wlpf_pkg::sample_t q_value,
  output logic             q_valid,
  output logic             lower
);
  import wlpf_pkg::*;

  sample_t value_r;
  logic    valid_r;

  // advance the flag, drop it at record end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clear) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= d_valid;
    end
  end

  // advance the sample
  always_ff @(posedge clk) begin
    if (shift_en) begin
      value_r <= d_value;
    end
  end

  // a neighbor counts only if it belongs to the record
  assign lower   = valid_r && (value_r < centre_value);
  assign q_value = value_r;
  assign q_valid = valid_r;

endmodule

// ===== rtl/core/wlpf_judge.sv =====
// Candidate rule for the sample in the centre cell of the window.
// Depends on wlpf_pkg; fed by the lower flags of the wlpf_cell row.
module wlpf_judge #(
  parameter int unsigned HALF_WINDOW = 8
) (
  input  wlpf_pkg::idx_t          centre_index,
  input  wlpf_pkg::sample_t       centre_value,
  input  wlpf_pkg::len_t          total,
  input  logic [HALF_WINDOW-1:0]  lower_left,
  input  logic [HALF_WINDOW-1:0]  lower_right,
  output wlpf_pkg::result_t       decision
);
  import wlpf_pkg::*;

  localparam int unsigned SPAN  = 2 * HALF_WINDOW + 1;
  localparam int unsigned CMP_W = LEN_W + 1;

  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] total_ext;
  logic full_l, full_r, any_l, any_r;
  logic near_start, start_edge, near_end, end_edge;
  logic cand;

  assign idx_ext   = CMP_W'(centre_index);
  assign total_ext = CMP_W'(total);

  // all lower, some lower, on each side
  assign full_l = &lower_left;
  assign full_r = &lower_right;
  assign any_l  = |lower_left;
  assign any_r  = |lower_right;

  // position relative to the record ends
  assign near_start = idx_ext <= CMP_W'(SPAN);
  assign start_edge = idx_ext <= CMP_W'(HALF_WINDOW);
  assign near_end   = (idx_ext + CMP_W'(SPAN)) >= total_ext;
  assign end_edge   = (idx_ext + CMP_W'(HALF_WINDOW)) >= total_ext;

  assign cand = (full_l && full_r)
             || (near_start && any_l && any_r)
             || (start_edge && full_r && !any_l)
             || (near_end && any_l && any_r)
             || (end_edge && full_l && !any_r);

  // build the decision word
  always_comb begin
    decision               = '0;
    decision.result_kind   = KIND_DECISION;
    decision.sample_index  = centre_index;
    decision.is_candidate  = cand;
    decision.decided_value = centre_value;
  end

endmodule

// ===== rtl/core/wlpf_top2.sv =====
// Tracks the two largest candidates of a record; earlier one wins a tie.
// Depends on wlpf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wlpf_top2 (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              note,
  input  logic              clear,
  input  wlpf_pkg::sample_t cand_value,
  input  wlpf_pkg::idx_t    cand_index,
  output wlpf_pkg::top2_t   top
);
  import wlpf_pkg::*;

  top2_t top_r;
  top2_t top_nxt;

  // insert a candidate as best or runner-up, pushing the old best down
  always_comb begin
    top_nxt = top_r;
    if (clear) begin
      top_nxt = '0;
    end else if (note) begin
      if (!top_r.best_valid || (cand_value > top_r.best_value)) begin
        top_nxt.runner_value = top_r.best_value;
        top_nxt.runner_index = top_r.best_index;
        top_nxt.runner_valid = top_r.best_valid;
        top_nxt.best_value   = cand_value;
        top_nxt.best_index   = cand_index;
        top_nxt.best_valid   = 1'b1;
      end else if (!top_r.runner_valid || (cand_value > top_r.runner_value)) begin
        top_nxt.runner_value = cand_value;
        top_nxt.runner_index = cand_index;
        top_nxt.runner_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r.best_valid   <= 1'b0;
      top_r.runner_valid <= 1'b0;
    end else begin
      top_r <= top_nxt;
    end
  end

  assign top = top_r;

  `ASSERT_NOW(a_top2_order, !top_r.runner_valid || (top_r.best_valid && (top_r.best_value >= top_r.runner_value)), "runner-up outranks best candidate")
  `ASSERT_NEXT(a_top2_clear, clear, !top_r.best_valid && !top_r.runner_valid, "candidates survive record end")

endmodule

// ===== rtl/core/wlpf_outq.sv =====
// Small result queue between the window row and the output channel.
// Depends on wlpf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wlpf_outq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  wlpf_pkg::result_t                   push_data,
  input  logic                                out_stall,
  output logic                                out_valid,
  output wlpf_pkg::result_t                   head,
  output logic [wlpf_pkg::OUTQ_CNT_W-1:0]     count
);
  import wlpf_pkg::*;

  function automatic logic [OUTQ_PTR_W-1:0] ptr_inc(input logic [OUTQ_PTR_W-1:0] p);
    logic [OUTQ_PTR_W-1:0] q;
    if (p == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + 1'b1;
    end
    return q;
  endfunction

  result_t                mem_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]  wr_ptr_r;
  logic [OUTQ_PTR_W-1:0]  rd_ptr_r;
  logic [OUTQ_CNT_W-1:0]  count_r;
  logic [OUTQ_CNT_W-1:0]  count_nxt;
  logic                   pop;

  assign pop       = (count_r != '0) && !out_stall;
  assign count_nxt = count_r + OUTQ_CNT_W'(push) - OUTQ_CNT_W'(pop);

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  // store the word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_valid = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign count     = count_r;

  `ASSERT_NOW(a_outq_room, !push || (count_r < OUTQ_CNT_W'(OUTQ_DEPTH)), "word pushed into a full queue")

endmodule
